[hdl/spq_pkg.sv]
// -----------------------------------------------------------------------------
// spq_pkg: shared types and helpers for the sorted priority queue
// Holds the store geometry, operation and status codes, the control
// record passed from the sequencer to the datapath, and index helpers.
// -----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		MODE_ENQ = 2'd0,
		MODE_DEQ = 2'd1,
		MODE_CLR = 2'd2,
		MODE_LST = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Source of the data written into the store
	typedef enum logic [1:0] {
		WSEL_IN   = 2'd0,
		WSEL_HELD = 2'd1,
		WSEL_RAM  = 2'd2
	} wsel_t;

	// Source of the value shown with a result
	typedef enum logic [1:0] {
		VSEL_ZERO = 2'd0,
		VSEL_IN   = 2'd1,
		VSEL_HELD = 2'd2,
		VSEL_RAM  = 2'd3
	} vsel_t;

	// Sequencer to datapath control for one cycle
	typedef struct packed {
		logic    we;
		idx_t    waddr;
		wsel_t   wsel;
		logic    re;
		idx_t    raddr;
		logic    emit;
		status_t status;
		vsel_t   vsel;
		logic    last;
	} ctl_t;

	// Step a circular index up by one
	function automatic idx_t idx_inc(input idx_t p);
		return (p == idx_t'(DEPTH - 1)) ? '0 : idx_t'(p + idx_t'(1));
	endfunction

	// Step a circular index down by one
	function automatic idx_t idx_dec(input idx_t p);
		return (p == '0) ? idx_t'(DEPTH - 1) : idx_t'(p - idx_t'(1));
	endfunction

	// Advance a circular index by n places, n no larger than DEPTH
	function automatic idx_t idx_add(input idx_t p, input cnt_t n);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(p) + (CNT_W + 1)'(n);
		if (s >= (CNT_W + 1)'(DEPTH)) begin
			s = s - (CNT_W + 1)'(DEPTH);
		end
		return idx_t'(s);
	endfunction

endpackage

`default_nettype wire

[hdl/spq_ram.sv]
// -----------------------------------------------------------------------------
// spq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// -----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hdl/spq_seq.sv]
// -----------------------------------------------------------------------------
// spq_seq: sequencer for the sorted priority queue
// Keeps the circular head pointer and fill count, walks the store one
// entry per cycle for insertion and listing, and drives the datapath.
// -----------------------------------------------------------------------------
`default_nettype none

module spq_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    mode,
	input  wire logic          gt,
	output logic               busy,
	output spq_pkg::ctl_t      ctl
);

	import spq_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_ENQ     = 5'b00010,
		S_ENQ_FIN = 5'b00100,
		S_DEQ     = 5'b01000,
		S_LST     = 5'b10000
	} state_t;

	state_t state_q, state_d;
	idx_t   hd_q, hd_d;
	cnt_t   cnt_q, cnt_d;
	idx_t   pos_q, pos_d;
	cnt_t   k_q, k_d;
	idx_t   tail;

	// Position of the last (largest) entry
	assign tail = idx_add(hd_q, cnt_t'(cnt_q - cnt_t'(1)));

	// Next state and per-cycle control
	always_comb begin
		state_d = state_q;
		hd_d    = hd_q;
		cnt_d   = cnt_q;
		pos_d   = pos_q;
		k_d     = k_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (mode_t'(mode))
						MODE_ENQ: begin
							if (cnt_q == cnt_t'(DEPTH)) begin
								ctl.emit   = 1'b1;
								ctl.status = ST_FULL;
								ctl.vsel   = VSEL_IN;
								ctl.last   = 1'b1;
							end else if (cnt_q == '0) begin
								ctl.we     = 1'b1;
								ctl.waddr  = hd_q;
								ctl.wsel   = WSEL_IN;
								cnt_d      = cnt_t'(1);
								ctl.emit   = 1'b1;
								ctl.status = ST_OK;
								ctl.vsel   = VSEL_IN;
								ctl.last   = 1'b1;
							end else begin
								ctl.re    = 1'b1;
								ctl.raddr = tail;
								pos_d     = tail;
								k_d       = cnt_q;
								state_d   = S_ENQ;
							end
						end
						MODE_DEQ: begin
							if (cnt_q == '0) begin
								ctl.emit   = 1'b1;
								ctl.status = ST_EMPTY;
								ctl.vsel   = VSEL_ZERO;
								ctl.last   = 1'b1;
							end else begin
								ctl.re    = 1'b1;
								ctl.raddr = hd_q;
								state_d   = S_DEQ;
							end
						end
						MODE_CLR: begin
							cnt_d      = '0;
							ctl.emit   = 1'b1;
							ctl.status = ST_OK;
							ctl.vsel   = VSEL_ZERO;
							ctl.last   = 1'b1;
						end
						default: begin
							if (cnt_q == '0) begin
								ctl.emit   = 1'b1;
								ctl.status = ST_EMPTY;
								ctl.vsel   = VSEL_ZERO;
								ctl.last   = 1'b1;
							end else begin
								ctl.re    = 1'b1;
								ctl.raddr = hd_q;
								pos_d     = hd_q;
								k_d       = cnt_q;
								state_d   = S_LST;
							end
						end
					endcase
				end
			end
			S_ENQ: begin
				ctl.we    = 1'b1;
				ctl.waddr = idx_inc(pos_q);
				if (gt) begin
					// Move the larger entry up one place and look further down
					ctl.wsel = WSEL_RAM;
					pos_d    = idx_dec(pos_q);
					if (k_q == cnt_t'(1)) begin
						state_d = S_ENQ_FIN;
					end else begin
						ctl.re    = 1'b1;
						ctl.raddr = idx_dec(pos_q);
						k_d       = cnt_t'(k_q - cnt_t'(1));
					end
				end else begin
					// Drop the new value in above the first entry not greater
					ctl.wsel   = WSEL_HELD;
					cnt_d      = cnt_t'(cnt_q + cnt_t'(1));
					ctl.emit   = 1'b1;
					ctl.status = ST_OK;
					ctl.vsel   = VSEL_HELD;
					ctl.last   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_ENQ_FIN: begin
				// New value is the smallest: place it at the head
				ctl.we     = 1'b1;
				ctl.waddr  = idx_inc(pos_q);
				ctl.wsel   = WSEL_HELD;
				cnt_d      = cnt_t'(cnt_q + cnt_t'(1));
				ctl.emit   = 1'b1;
				ctl.status = ST_OK;
				ctl.vsel   = VSEL_HELD;
				ctl.last   = 1'b1;
				state_d    = S_IDLE;
			end
			S_DEQ: begin
				ctl.emit   = 1'b1;
				ctl.status = ST_OK;
				ctl.vsel   = VSEL_RAM;
				ctl.last   = 1'b1;
				hd_d       = idx_inc(hd_q);
				cnt_d      = cnt_t'(cnt_q - cnt_t'(1));
				state_d    = S_IDLE;
			end
			S_LST: begin
				ctl.emit   = 1'b1;
				ctl.status = ST_OK;
				ctl.vsel   = VSEL_RAM;
				ctl.last   = (k_q == cnt_t'(1));
				if (k_q == cnt_t'(1)) begin
					state_d = S_IDLE;
				end else begin
					ctl.re    = 1'b1;
					ctl.raddr = idx_inc(pos_q);
					pos_d     = idx_inc(pos_q);
					k_d       = cnt_t'(k_q - cnt_t'(1));
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hd_q    <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			hd_q    <= hd_d;
			cnt_q   <= cnt_d;
		end
	end

	// Walk pointer and remaining count
	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		k_q   <= k_d;
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

[hdl/sorted_priority_queue.sv]
// -----------------------------------------------------------------------------
// sorted_priority_queue: min-priority queue over a sorted circular store
// Enqueue, dequeue, clear and list commands on signed 32-bit values; the
// store is walked one entry per cycle through a single compare unit.
// -----------------------------------------------------------------------------
// Results: the registered strobe rises in the cycle after the last busy cycle
//   (or after the transfer when the command completes at once). Results cannot
//   be stalled. Enqueue completes at once when empty or full, else its length
//   is set by the insertion walk through the single RAM read port. Dequeue
//   reads the head, then gives it; list gives one result per cycle. Both end
//   at once when empty, as does clear. Reset empties the queue, not the store.
`default_nettype none

module sorted_priority_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [1:0]            mode,
	input  wire logic signed [31:0]    value,
	output logic                       busy,
	output logic                       strobe,
	output logic [1:0]                 status,
	output logic signed [31:0]         value_res,
	output logic                       last
);

	import spq_pkg::*;

	ctl_t  ctl;
	data_t val_q;
	data_t rdata;
	data_t wdata;
	data_t res_val;
	logic  gt;
	logic  strobe_q;
	logic  [1:0] status_q;
	data_t value_q;
	logic  last_q;

	spq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.gt     (gt),
		.busy   (busy),
		.ctl    (ctl)
	);

	spq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ctl.we),
		.waddr (ctl.waddr),
		.wdata (wdata),
		.re    (ctl.re),
		.raddr (ctl.raddr),
		.rdata (rdata)
	);

	// Hold the command value for the insertion walk
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			val_q <= value;
		end
	end

	// Shared compare unit: stored entry greater than the new value
	assign gt = (rdata > val_q);

	// Select write data
	always_comb begin
		case (ctl.wsel)
			WSEL_IN:   wdata = value;
			WSEL_HELD: wdata = val_q;
			WSEL_RAM:  wdata = rdata;
			default:   wdata = rdata;
		endcase
	end

	// Select result value
	always_comb begin
		case (ctl.vsel)
			VSEL_ZERO: res_val = '0;
			VSEL_IN:   res_val = value;
			VSEL_HELD: res_val = val_q;
			VSEL_RAM:  res_val = rdata;
			default:   res_val = '0;
		endcase
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.emit;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			status_q <= ctl.status;
			value_q  <= res_val;
			last_q   <= ctl.last;
		end
	end

	assign strobe    = strobe_q;
	assign status    = status_q;
	assign value_res = value_q;
	assign last      = last_q;

endmodule

`default_nettype wire

[hdl/spq_chk.sv]
// -----------------------------------------------------------------------------
// spq_chk: port-level checker for the sorted priority queue
// Watches command transfers and result strobes on the top-level ports.
// -----------------------------------------------------------------------------
`default_nettype none

module spq_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic [1:0]        mode,
	input wire logic              busy,
	input wire logic              strobe,
	input wire logic [1:0]        status,
	input wire logic              last
);

	import spq_pkg::*;

	// Clear completes at once with an ok final result
	a_clr_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_CLR) |=> (strobe && last && status == ST_OK))
		else $error("clear did not give a single ok result");

	// A list run continues without gaps until its final result
	a_list_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe)
		else $error("gap inside a list run");

	// A non-final result only occurs while the command is still running
	a_nonlast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("non-final result while idle");

	// Leaving busy is always marked by the final result
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last))
		else $error("command ended without a final result");

	// Status never carries an unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (status == ST_OK || status == ST_FULL || status == ST_EMPTY))
		else $error("unused status code");

endmodule

bind sorted_priority_queue spq_chk u_spq_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.mode   (mode),
	.busy   (busy),
	.strobe (strobe),
	.status (status),
	.last   (last)
);

`default_nettype wire

[tb/testbench.sv]
// -----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted priority queue
// A queue of commands drives the block through its start/busy handshake with
// random idle bursts. A software copy of the sorted store predicts every result,
// and the monitor checks each strobed result against the oldest prediction.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	import spq_pkg::*;

	localparam int RUN_ITEMS  = 210;
	localparam int TAIL_ITEMS = 30;
	localparam int MAX_CYCLES = 200000;
	localparam int DRAIN_WAIT = 24;

	typedef struct {
		mode_t mode;
		data_t value;
	} cmd_t;

	typedef struct {
		status_t status;
		data_t   value;
		logic    last;
	} result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        mode = 2'd0;
	logic signed [31:0] value = '0;
	logic              busy;
	logic              strobe;
	logic [1:0]        status;
	logic signed [31:0] value_res;
	logic              last;

	cmd_t    pending_cmds[$];
	result_t expected_results[$];

	// Software copy of the sorted store
	data_t model_store[DEPTH];
	int    model_fill = 0;

	// Fill level as seen while building the command list
	int gen_fill = 0;

	int gap_left = 0;
	int err_count = 0;
	int cycle_count = 0;

	sorted_priority_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.value     (value),
		.busy      (busy),
		.strobe    (strobe),
		.status    (status),
		.value_res (value_res),
		.last      (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void push_result(status_t st, data_t v, logic lst);
		result_t r;
		r.status = st;
		r.value  = v;
		r.last   = lst;
		expected_results.push_back(r);
	endfunction

	// Apply one accepted command to the store copy and queue its results
	function automatic void predict_results(mode_t m, data_t v);
		int i;
		case (m)
			MODE_ENQ: begin
				if (model_fill >= DEPTH) begin
					push_result(ST_FULL, v, 1'b1);
				end else begin
					// insert after any equal entries
					i = model_fill;
					while (i > 0 && model_store[i-1] > v) begin
						model_store[i] = model_store[i-1];
						i--;
					end
					model_store[i] = v;
					model_fill++;
					push_result(ST_OK, v, 1'b1);
				end
			end
			MODE_DEQ: begin
				if (model_fill == 0) begin
					push_result(ST_EMPTY, '0, 1'b1);
				end else begin
					push_result(ST_OK, model_store[0], 1'b1);
					for (i = 1; i < model_fill; i++) begin
						model_store[i-1] = model_store[i];
					end
					model_fill--;
				end
			end
			MODE_CLR: begin
				model_fill = 0;
				push_result(ST_OK, '0, 1'b1);
			end
			default: begin
				if (model_fill == 0) begin
					push_result(ST_EMPTY, '0, 1'b1);
				end else begin
					for (i = 0; i < model_fill; i++) begin
						push_result(ST_OK, model_store[i], (i == model_fill - 1));
					end
				end
			end
		endcase
	endfunction

	// Queue one command and track the fill level it leads to
	function automatic void add_cmd(mode_t m, data_t v);
		cmd_t c;
		c.mode  = m;
		c.value = v;
		pending_cmds.push_back(c);
		case (m)
			MODE_ENQ: if (gen_fill < DEPTH) gen_fill++;
			MODE_DEQ: if (gen_fill > 0) gen_fill--;
			MODE_CLR: gen_fill = 0;
			default: ;
		endcase
	endfunction

	// Random value biased toward extremes and small clustered values
	function automatic data_t pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			4, 5: return data_t'($urandom_range(0, 8)) - 32'sd4;
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic mode_t pick_mode();
		return mode_t'($urandom_range(0, 3));
	endfunction

	task automatic build_cmds();
		int n;
		int k;
		// directed: empty cases, extremes, equal values, ordering, clear
		add_cmd(MODE_LST, 32'sh5A5A5A5A);
		add_cmd(MODE_DEQ, -32'sd1);
		add_cmd(MODE_CLR, 32'sh7FFFFFFF);
		add_cmd(MODE_ENQ, 32'sh7FFFFFFF);
		add_cmd(MODE_ENQ, 32'sh80000000);
		add_cmd(MODE_ENQ, '0);
		add_cmd(MODE_ENQ, -32'sd1);
		add_cmd(MODE_ENQ, 32'sd5);
		add_cmd(MODE_ENQ, 32'sd5);
		add_cmd(MODE_ENQ, 32'sd1);
		add_cmd(MODE_LST, '0);
		add_cmd(MODE_DEQ, 32'sh80000000);
		add_cmd(MODE_DEQ, '0);
		add_cmd(MODE_LST, '0);
		add_cmd(MODE_CLR, '0);
		add_cmd(MODE_LST, -32'sd1);
		add_cmd(MODE_DEQ, '0);
		add_cmd(MODE_ENQ, 32'sd3);
		add_cmd(MODE_DEQ, '0);
		add_cmd(MODE_DEQ, '0);
		// random episodes
		while (pending_cmds.size() < RUN_ITEMS) begin
			case ($urandom_range(0, 5))
				0, 1: begin
					// fill to full, push up to two past it, then list
					n = DEPTH - gen_fill + $urandom_range(0, 2);
					for (k = 0; k < n; k++) add_cmd(MODE_ENQ, pick_value());
					add_cmd(MODE_LST, data_t'($urandom));
				end
				2: begin
					// drain past empty
					n = gen_fill + $urandom_range(1, 2);
					for (k = 0; k < n; k++) add_cmd(MODE_DEQ, data_t'($urandom));
					add_cmd(MODE_LST, data_t'($urandom));
				end
				3: begin
					add_cmd(MODE_CLR, data_t'($urandom));
				end
				default: begin
					// mixed operations
					n = $urandom_range(3, 10);
					for (k = 0; k < n; k++) add_cmd(pick_mode(), pick_value());
				end
			endcase
		end
	endtask

	// Driver: hold the command until transfer, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		logic next_start;
		cmd_t c;
		if (!arst_n) begin
			start <= 1'b0;
			mode  <= 2'd0;
			value <= '0;
		end else begin
			next_start = start;
			if (start && !busy) begin
				predict_results(mode_t'(mode), value);
			end
			if (!(start && busy)) begin
				next_start = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() > 0) begin
					if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
						gap_left = $urandom_range(0, 11);
					end else begin
						c = pending_cmds.pop_front();
						mode  <= c.mode;
						value <= c.value;
						next_start = 1'b1;
					end
				end
			end
			start <= next_start;
		end
	end

	// Monitor: compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		result_t r;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d value_res %0d last %0d",
					status, value_res, last);
				err_count++;
			end else begin
				r = expected_results.pop_front();
				if (status !== r.status) begin
					$error("status: expected %0d, actual %0d", r.status, status);
					err_count++;
				end
				if (value_res !== r.value) begin
					$error("value_res: expected %0d, actual %0d", r.value, value_res);
					err_count++;
				end
				if (last !== r.last) begin
					$error("last: expected %0d, actual %0d", r.last, last);
					err_count++;
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= MAX_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		build_cmds();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// wait for every command to transfer and every result to arrive
		while (pending_cmds.size() > 0 || start || gap_left > 0) @(posedge clk);
		while (expected_results.size() > 0 || busy) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
